/* rtl/rilbp_pkg.sv */
// shared types, codes and constants of the address-range list parser
package rilbp_pkg;

  // parse phases
  typedef enum logic [3:0] {
    PH_MAGIC     = 4'd0,
    PH_VERSION   = 4'd1,
    PH_V12_NAME  = 4'd2,
    PH_V12_FIRST = 4'd3,
    PH_V12_LAST  = 4'd4,
    PH_V3_NCOUNT = 4'd5,
    PH_V3_NAMES  = 4'd6,
    PH_V3_RCOUNT = 4'd7,
    PH_V3_IDX    = 4'd8,
    PH_V3_FIRST  = 4'd9,
    PH_V3_LAST   = 4'd10,
    PH_DONE      = 4'd11,
    PH_ERROR     = 4'd12
  } phase_t;

  // result kinds
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_RANGE = 2'd0;
  localparam kind_t KIND_DONE  = 2'd1;
  localparam kind_t KIND_ERR   = 2'd2;

  // header bytes before the version
  localparam int unsigned MAGIC_LEN = 7;

  // accepted version codes
  localparam logic [7:0] VER_V1 = 8'd1;
  localparam logic [7:0] VER_V2 = 8'd2;
  localparam logic [7:0] VER_V3 = 8'd3;

  // name terminator
  localparam logic [7:0] NAME_END = 8'h00;

  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'hFF;
      3'd1:    b = 8'hFF;
      3'd2:    b = 8'hFF;
      3'd3:    b = 8'hFF;
      3'd4:    b = 8'h50;
      3'd5:    b = 8'h32;
      3'd6:    b = 8'h42;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // one result item
  typedef struct packed {
    kind_t       kind;
    logic [31:0] first;
    logic [31:0] last;
    logic [31:0] rules;
    logic        run_end;
  } result_t;

  // results produced by one byte, in order
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

  // result buffer status
  typedef struct packed {
    logic [1:0] count;
    logic       room;
  } ob_stat_t;

endpackage

/* rtl/rilbp_if.sv */
// byte and result channel interfaces
interface rilbp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_end;

  modport source (output valid, output data_byte, output stream_end, input ready);
  modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

interface rilbp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [31:0] range_first;
  logic [31:0] range_last;
  logic [31:0] rules_so_far;
  logic        run_end;

  modport source (output valid, output result_kind, output range_first, output range_last,
                  output rules_so_far, output run_end, input ready);
  modport sink   (input valid, input result_kind, input range_first, input range_last,
                  input rules_so_far, input run_end, output ready);
endinterface

/* rtl/rilbp_parse.sv */
// parse state and single-byte step logic
module rilbp_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  logic [7:0]          data_byte,
  input  logic                stream_end,
  output rilbp_pkg::push_t    push
);

  rilbp_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [31:0] word_r, word_nxt;
  logic [31:0] first_r, first_nxt;
  logic [31:0] names_r, names_nxt;
  logic [31:0] ranges_r, ranges_nxt;
  logic [31:0] total_r, total_nxt;

  logic        fail;
  logic        emit;
  logic        report;
  logic        clean;
  logic        was_error;
  logic        word_done;
  logic [31:0] word_in;
  rilbp_pkg::result_t range_res;
  rilbp_pkg::result_t report_res;

  always_comb begin
    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    word_nxt   = word_r;
    first_nxt  = first_r;
    names_nxt  = names_r;
    ranges_nxt = ranges_r;
    total_nxt  = total_r;
    fail       = 1'b0;
    emit       = 1'b0;
    was_error  = (phase_r == rilbp_pkg::PH_ERROR);
    word_done  = (idx_r == 3'd3);
    word_in    = {word_r[23:0], data_byte};

    case (phase_r)
      rilbp_pkg::PH_MAGIC: begin
        if (data_byte != rilbp_pkg::magic_byte(idx_r)) begin
          fail = 1'b1;
        end else if (idx_r == 3'(rilbp_pkg::MAGIC_LEN - 1)) begin
          idx_nxt   = 3'd0;
          phase_nxt = rilbp_pkg::PH_VERSION;
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
      end
      rilbp_pkg::PH_VERSION: begin
        idx_nxt = 3'd0;
        if (data_byte == rilbp_pkg::VER_V1 || data_byte == rilbp_pkg::VER_V2) begin
          phase_nxt = rilbp_pkg::PH_V12_NAME;
        end else if (data_byte == rilbp_pkg::VER_V3) begin
          phase_nxt = rilbp_pkg::PH_V3_NCOUNT;
        end else begin
          fail = 1'b1;
        end
      end
      rilbp_pkg::PH_V12_NAME: begin
        if (data_byte == rilbp_pkg::NAME_END) begin
          idx_nxt   = 3'd0;
          phase_nxt = rilbp_pkg::PH_V12_FIRST;
        end else begin
          idx_nxt = 3'd1;
        end
      end
      rilbp_pkg::PH_V12_FIRST: begin
        word_nxt = word_in;
        idx_nxt  = word_done ? 3'd0 : idx_r + 3'd1;
        if (word_done) begin
          first_nxt = word_in;
          phase_nxt = rilbp_pkg::PH_V12_LAST;
        end
      end
      rilbp_pkg::PH_V12_LAST: begin
        word_nxt = word_in;
        idx_nxt  = word_done ? 3'd0 : idx_r + 3'd1;
        if (word_done) begin
          emit      = 1'b1;
          phase_nxt = rilbp_pkg::PH_V12_NAME;
        end
      end
      rilbp_pkg::PH_V3_NCOUNT: begin
        word_nxt = word_in;
        idx_nxt  = word_done ? 3'd0 : idx_r + 3'd1;
        if (word_done) begin
          names_nxt = word_in;
          phase_nxt = (word_in != 32'd0) ? rilbp_pkg::PH_V3_NAMES : rilbp_pkg::PH_V3_RCOUNT;
        end
      end
      rilbp_pkg::PH_V3_NAMES: begin
        if (data_byte == rilbp_pkg::NAME_END) begin
          names_nxt = names_r - 32'd1;
          if (names_r == 32'd1) begin
            phase_nxt = rilbp_pkg::PH_V3_RCOUNT;
          end
        end
      end
      rilbp_pkg::PH_V3_RCOUNT: begin
        word_nxt = word_in;
        idx_nxt  = word_done ? 3'd0 : idx_r + 3'd1;
        if (word_done) begin
          ranges_nxt = word_in;
          phase_nxt  = (word_in != 32'd0) ? rilbp_pkg::PH_V3_IDX : rilbp_pkg::PH_DONE;
        end
      end
      rilbp_pkg::PH_V3_IDX: begin
        word_nxt = word_in;
        idx_nxt  = word_done ? 3'd0 : idx_r + 3'd1;
        if (word_done) begin
          phase_nxt = rilbp_pkg::PH_V3_FIRST;
        end
      end
      rilbp_pkg::PH_V3_FIRST: begin
        word_nxt = word_in;
        idx_nxt  = word_done ? 3'd0 : idx_r + 3'd1;
        if (word_done) begin
          first_nxt = word_in;
          phase_nxt = rilbp_pkg::PH_V3_LAST;
        end
      end
      rilbp_pkg::PH_V3_LAST: begin
        word_nxt = word_in;
        idx_nxt  = word_done ? 3'd0 : idx_r + 3'd1;
        if (word_done) begin
          emit       = 1'b1;
          ranges_nxt = ranges_r - 32'd1;
          phase_nxt  = (ranges_r != 32'd1) ? rilbp_pkg::PH_V3_IDX : rilbp_pkg::PH_DONE;
        end
      end
      default: begin
      end
    endcase

    if (emit && total_r != 32'hFFFF_FFFF) begin
      total_nxt = total_r + 32'd1;
    end

    if (fail) begin
      phase_nxt = rilbp_pkg::PH_ERROR;
    end

    clean  = (phase_nxt == rilbp_pkg::PH_DONE) ||
             (phase_nxt == rilbp_pkg::PH_V12_NAME && idx_nxt == 3'd0);
    report = fail || (stream_end && !was_error);

    range_res.kind    = rilbp_pkg::KIND_RANGE;
    range_res.first   = first_r;
    range_res.last    = word_in;
    range_res.rules   = total_nxt;
    range_res.run_end = !report;

    report_res.kind    = (!fail && clean) ? rilbp_pkg::KIND_DONE : rilbp_pkg::KIND_ERR;
    report_res.first   = 32'd0;
    report_res.last    = 32'd0;
    report_res.rules   = total_nxt;
    report_res.run_end = 1'b1;

    push.count = {1'b0, emit} + {1'b0, report};
    if (emit) begin
      push.r0 = range_res;
      push.r1 = report_res;
    end else begin
      push.r0 = report_res;
      push.r1 = '0;
    end

    // last byte of a stream returns to the header phase
    if (stream_end) begin
      phase_nxt  = rilbp_pkg::PH_MAGIC;
      idx_nxt    = 3'd0;
      word_nxt   = 32'd0;
      first_nxt  = 32'd0;
      names_nxt  = 32'd0;
      ranges_nxt = 32'd0;
      total_nxt  = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= rilbp_pkg::PH_MAGIC;
      idx_r    <= 3'd0;
      word_r   <= 32'd0;
      first_r  <= 32'd0;
      names_r  <= 32'd0;
      ranges_r <= 32'd0;
      total_r  <= 32'd0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      word_r   <= word_nxt;
      first_r  <= first_nxt;
      names_r  <= names_nxt;
      ranges_r <= ranges_nxt;
      total_r  <= total_nxt;
    end
  end

endmodule

/* rtl/rilbp_outbuf.sv */
// two-slot result buffer, head slot drives the result channel
module rilbp_outbuf (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_en,
  input  rilbp_pkg::push_t      push,
  input  logic                  pop,
  output rilbp_pkg::result_t    head,
  output rilbp_pkg::ob_stat_t   stat
);

  rilbp_pkg::result_t slot0_r, slot0_nxt;
  rilbp_pkg::result_t slot1_r, slot1_nxt;
  logic [1:0] count_r, count_nxt;
  logic [1:0] cnt_after;

  always_comb begin
    cnt_after = count_r - {1'b0, pop};
    slot0_nxt = pop ? slot1_r : slot0_r;
    slot1_nxt = slot1_r;
    count_nxt = cnt_after;
    // new results only land in an empty buffer
    if (push_en && push.count != 2'd0) begin
      slot0_nxt = push.r0;
      slot1_nxt = push.r1;
      count_nxt = push.count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  assign head       = slot0_r;
  assign stat.count = count_r;
  assign stat.room  = (cnt_after == 2'd0);

endmodule

/* rtl/ip_range_list_binary_parser_top.sv */
// top level of the binary address-range list parser
//
//  channel   dir  handshake      payload
//  in_chan   in   valid/ready    data_byte[7:0], stream_end
//  out_chan  out  valid/ready    result_kind[1:0], range_first[31:0], range_last[31:0],
//                                rules_so_far[31:0], run_end
//
// one byte per cycle while results fit: a byte lands in the input register, is parsed
// from there and its results are registered into the result buffer that drives out_chan
// a byte that completes a record and ends the stream gives two results, which drain
// one at a time; that drain is what sets the rate in that case
// a byte waits in the input register until the result buffer is empty after this
// cycle's pop; a byte with no result never waits
// rst_n is synchronous, active low, and returns the parser to the header phase
module ip_range_list_binary_parser_top (
  input logic          clk,
  input logic          rst_n,
  rilbp_in_if.sink     in_chan,
  rilbp_out_if.source  out_chan
);

  // input register
  logic       inq_valid_r;
  logic [7:0] inq_byte_r;
  logic       inq_end_r;

  rilbp_pkg::push_t    push;
  rilbp_pkg::result_t  head;
  rilbp_pkg::ob_stat_t ob_stat;

  logic fire_proc;
  logic in_fire;
  logic pop;

  // parse the held byte when its results fit, or when it makes none
  assign fire_proc = inq_valid_r && (ob_stat.room || push.count == 2'd0);
  assign in_chan.ready = !inq_valid_r || fire_proc;
  assign in_fire = in_chan.valid && in_chan.ready;
  assign pop = out_chan.valid && out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
    end else if (in_fire) begin
      inq_valid_r <= 1'b1;
    end else if (fire_proc) begin
      inq_valid_r <= 1'b0;
    end
  end

  // payload holds no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      inq_byte_r <= in_chan.data_byte;
      inq_end_r  <= in_chan.stream_end;
    end
  end

  rilbp_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (fire_proc),
    .data_byte  (inq_byte_r),
    .stream_end (inq_end_r),
    .push       (push)
  );

  rilbp_outbuf u_outbuf (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_en (fire_proc),
    .push    (push),
    .pop     (pop),
    .head    (head),
    .stat    (ob_stat)
  );

  assign out_chan.valid        = (ob_stat.count != 2'd0);
  assign out_chan.result_kind  = head.kind;
  assign out_chan.range_first  = head.first;
  assign out_chan.range_last   = head.last;
  assign out_chan.rules_so_far = head.rules;
  assign out_chan.run_end      = head.run_end;

  // buffer never holds more than two results
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    ob_stat.count != 2'd3)
    else $error("result buffer overfilled");

  // a result that is not the last of its byte always has its follower queued
  a_pair_queued: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !out_chan.run_end |-> ob_stat.count == 2'd2)
    else $error("first result of a pair without its follower");

  // a two-result byte is a range followed by the closing report
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    fire_proc && push.count == 2'd2 |->
      push.r0.kind == rilbp_pkg::KIND_RANGE && !push.r0.run_end && push.r1.run_end)
    else $error("bad result pair order");

  // a held byte is never stuck behind an empty buffer
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    inq_valid_r && ob_stat.count == 2'd0 |-> fire_proc)
    else $error("byte held while result buffer empty");

endmodule
